FILE: design/tmcs_pkg.sv
// ----------------------------------------------------------------------------
// tmcs_pkg: shared types and constants for the contrast stretch block
// Command codes, fixed field widths, parameter defaults and the control
// bundles passed between the sequencer, the histogram store and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tmcs_pkg;

   localparam int PIX_W           = 8;
   localparam int CMD_W           = 2;
   localparam int QUOT_W          = 8;
   localparam int NUM_BINS        = 256;
   localparam int COUNT_WIDTH_DEF = 24;
   localparam int MAX_ROUNDS_DEF  = 64;

   localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACC   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_MAP   = 2'd3;

   typedef struct packed {
      logic             clear;
      logic             rd_en;
      logic [PIX_W-1:0] rd_addr;
      logic             wr_en;
      logic [PIX_W-1:0] wr_addr;
   } hist_ctl_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_res_type;

endpackage

`default_nettype wire

FILE: design/tmcs_if.sv
// ----------------------------------------------------------------------------
// tmcs_if: request and response channels of the contrast stretch block
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmcs_req_if import tmcs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, cmd, pixel, input ready);
   modport sink   (input valid, cmd, pixel, output ready);
endinterface

interface tmcs_rsp_if import tmcs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] mapped_pixel;
   logic [PIX_W-1:0] black_level;
   logic [PIX_W-1:0] white_level;
   logic             hit_round_cap;

   modport source (output valid, mapped_pixel, black_level, white_level, hit_round_cap,
                   input ready);
   modport sink   (input valid, mapped_pixel, black_level, white_level, hit_round_cap,
                   output ready);
endinterface

`default_nettype wire

FILE: design/tmcs_hist.sv
// ----------------------------------------------------------------------------
// tmcs_hist: 256-bin histogram store
// One write and one registered read port. A valid bit per bin lets a clear
// empty every bin at once; an invalid bin reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcs_hist import tmcs_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hist_ctl_type           ctl,
   input  wire logic [COUNT_WIDTH-1:0] wr_data,
   output      logic [COUNT_WIDTH-1:0] rd_data
);

   logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
   logic [NUM_BINS-1:0]    vld_ff;
   logic [COUNT_WIDTH-1:0] rd_mem_ff;
   logic                   rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.clear) begin
         vld_ff <= '0;
      end else if (ctl.wr_en) begin
         vld_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_mem_ff <= mem[ctl.rd_addr];
         rd_vld_ff <= vld_ff[ctl.rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_mem_ff : '0;

endmodule

`default_nettype wire

FILE: design/tmcs_div.sv
// ----------------------------------------------------------------------------
// tmcs_div: shared restoring divider, one quotient bit per cycle
// Caller guarantees the quotient fits in QUOT_W bits (dividend < divisor
// shifted up by QUOT_W). Result is flagged by a one-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcs_div import tmcs_pkg::*; #(
   parameter int DIVIDEND_W = COUNT_WIDTH_DEF + 16,
   parameter int DIVISOR_W  = COUNT_WIDTH_DEF + 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output      div_res_type           res
);

   localparam int SH_W  = DIVISOR_W + QUOT_W - 1;
   localparam int CMP_W = (SH_W > DIVIDEND_W) ? SH_W : DIVIDEND_W;
   localparam int CNT_W = $clog2(QUOT_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [SH_W-1:0]       dsh_ff, dsh_in;
   logic [QUOT_W-1:0]     q_ff, q_in;

   logic [CMP_W-1:0] rem_x;
   logic [CMP_W-1:0] dsh_x;
   logic [CMP_W-1:0] diff;
   logic             ge;

   assign rem_x = CMP_W'(rem_ff);
   assign dsh_x = CMP_W'(dsh_ff);
   assign ge    = (rem_x >= dsh_x);
   assign diff  = rem_x - dsh_x;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUOT_W - 1);
         rem_in  = dividend;
         dsh_in  = {divisor, {(QUOT_W-1){1'b0}}};
         q_in    = '0;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = diff[DIVIDEND_W-1:0];
         end
         q_in   = {q_ff[QUOT_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign res.done = done_ff;
   assign res.quot = q_ff;

endmodule

`default_nettype wire

FILE: design/two_means_contrast_stretch.sv
// ----------------------------------------------------------------------------
// two_means_contrast_stretch: histogram-based automatic contrast stretch
// Sequencer around a histogram store and a shared iterative divider.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle. Clear completes in the
// accept cycle, accumulate reads then writes back (read-modify-write of the
// histogram's single read port), and a map waits in ST_MAP_WAIT for the
// 8-step divider only when scaling is needed. A solve walks the 256 bins
// once per round through the one read port and then runs up to two 8-step
// divisions, for at most MAX_ROUNDS rounds. A finished response waits in an
// output register, so the next request can be taken while it is not yet
// consumed. Clear and accumulate produce no response.
`default_nettype none

module two_means_contrast_stretch import tmcs_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   parameter int MAX_ROUNDS  = MAX_ROUNDS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   tmcs_req_if.sink   req_chan,
   tmcs_rsp_if.source rsp_chan
);

   localparam int CW     = COUNT_WIDTH;
   localparam int NSUM_W = CW + 8;
   localparam int SUM_W  = CW + 16;
   localparam int RND_W  = $clog2(MAX_ROUNDS + 1);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_ACC_WR    = 4'd1;
   localparam logic [3:0] ST_SCAN      = 4'd2;
   localparam logic [3:0] ST_TAIL      = 4'd3;
   localparam logic [3:0] ST_DIVB      = 4'd4;
   localparam logic [3:0] ST_DIVB_WAIT = 4'd5;
   localparam logic [3:0] ST_DIVW      = 4'd6;
   localparam logic [3:0] ST_DIVW_WAIT = 4'd7;
   localparam logic [3:0] ST_NEXT      = 4'd8;
   localparam logic [3:0] ST_MAP_WAIT  = 4'd9;
   localparam logic [3:0] ST_RESULT    = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [PIX_W-1:0]  black_ff, black_in;
   logic [PIX_W-1:0]  white_ff, white_in;
   logic              cap_ff, cap_in;
   logic [RND_W-1:0]  round_ff, round_in;
   logic [PIX_W-1:0]  scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [PIX_W-1:0]  idx_ff, idx_in;
   logic [SUM_W-1:0]  sum_b_ff, sum_b_in;
   logic [SUM_W-1:0]  sum_w_ff, sum_w_in;
   logic [NSUM_W-1:0] n_b_ff, n_b_in;
   logic [NSUM_W-1:0] n_w_ff, n_w_in;
   logic [PIX_W-1:0]  nb_ff, nb_in;
   logic [PIX_W-1:0]  nw_ff, nw_in;
   logic [PIX_W-1:0]  pix_ff, pix_in;
   logic [PIX_W-1:0]  res_pix_ff, res_pix_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pix_ff, rsp_pix_in;
   logic [PIX_W-1:0]  rsp_black_ff, rsp_black_in;
   logic [PIX_W-1:0]  rsp_white_ff, rsp_white_in;
   logic              rsp_cap_ff, rsp_cap_in;

   hist_ctl_type      hctl;
   logic [CW-1:0]     hist_wr;
   logic [CW-1:0]     hist_rd;

   logic              div_start;
   logic [SUM_W-1:0]  div_dividend;
   logic [NSUM_W-1:0] div_divisor;
   div_res_type       div_res;

   logic              req_fire;
   logic [PIX_W-1:0]  db, dw;
   logic              to_black;
   logic [CW+7:0]     prod;
   logic [PIX_W-1:0]  span;
   logic [PIX_W-1:0]  pdiff;
   logic [15:0]       pscaled;
   logic              moved;

   tmcs_hist #(.COUNT_WIDTH(CW)) u_hist (
      .clock   (clock),
      .reset   (reset),
      .ctl     (hctl),
      .wr_data (hist_wr),
      .rd_data (hist_rd)
   );

   tmcs_div #(.DIVIDEND_W(SUM_W), .DIVISOR_W(NSUM_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .res      (div_res)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == ST_IDLE);

   // distance of the bin being summed to each level; ties go to white
   assign db       = (idx_ff > black_ff) ? (idx_ff - black_ff) : (black_ff - idx_ff);
   assign dw       = (idx_ff > white_ff) ? (idx_ff - white_ff) : (white_ff - idx_ff);
   assign to_black = (db < dw);
   assign prod     = hist_rd * idx_ff;

   assign span    = white_ff - black_ff;
   assign pdiff   = req_chan.pixel - black_ff;
   assign pscaled = {pdiff, 8'd0} - {8'd0, pdiff};   // pdiff * 255
   assign moved   = (nb_ff != black_ff) || (nw_ff != white_ff);

   always_comb begin
      state_in     = state_ff;
      black_in     = black_ff;
      white_in     = white_ff;
      cap_in       = cap_ff;
      round_in     = round_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      idx_in       = idx_ff;
      sum_b_in     = sum_b_ff;
      sum_w_in     = sum_w_ff;
      n_b_in       = n_b_ff;
      n_w_in       = n_w_ff;
      nb_in        = nb_ff;
      nw_in        = nw_ff;
      pix_in       = pix_ff;
      res_pix_in   = res_pix_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_black_in = rsp_black_ff;
      rsp_white_in = rsp_white_ff;
      rsp_cap_in   = rsp_cap_ff;
      hctl         = '0;
      hist_wr      = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // class sums, one bin per cycle behind the scan read
      if (pend_ff) begin
         if (to_black) begin
            sum_b_in = sum_b_ff + SUM_W'(prod);
            n_b_in   = n_b_ff + NSUM_W'(hist_rd);
         end else begin
            sum_w_in = sum_w_ff + SUM_W'(prod);
            n_w_in   = n_w_ff + NSUM_W'(hist_rd);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.cmd)
                  CMD_CLEAR: begin
                     hctl.clear = 1'b1;
                  end
                  CMD_ACC: begin
                     hctl.rd_en   = 1'b1;
                     hctl.rd_addr = req_chan.pixel;
                     pix_in       = req_chan.pixel;
                     state_in     = ST_ACC_WR;
                  end
                  CMD_SOLVE: begin
                     black_in = '0;
                     white_in = FULL_SCALE;
                     round_in = '0;
                     scan_in  = '0;
                     sum_b_in = '0;
                     sum_w_in = '0;
                     n_b_in   = '0;
                     n_w_in   = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     // map: pass-through on full, empty or inverted span
                     if ((white_ff <= black_ff) || (span == FULL_SCALE)) begin
                        res_pix_in = req_chan.pixel;
                        state_in   = ST_RESULT;
                     end else if (req_chan.pixel < black_ff) begin
                        res_pix_in = '0;
                        state_in   = ST_RESULT;
                     end else if (req_chan.pixel > white_ff) begin
                        res_pix_in = FULL_SCALE;
                        state_in   = ST_RESULT;
                     end else begin
                        div_start    = 1'b1;
                        div_dividend = SUM_W'(pscaled);
                        div_divisor  = NSUM_W'(span);
                        state_in     = ST_MAP_WAIT;
                     end
                  end
               endcase
            end
         end
         ST_ACC_WR: begin
            hctl.wr_en   = 1'b1;
            hctl.wr_addr = pix_ff;
            hist_wr      = (hist_rd == {CW{1'b1}}) ? hist_rd : hist_rd + 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            hctl.rd_en   = 1'b1;
            hctl.rd_addr = scan_ff;
            pend_in      = 1'b1;
            idx_in       = scan_ff;
            scan_in      = scan_ff + 1'b1;
            if (scan_ff == FULL_SCALE) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_DIVB;
         end
         ST_DIVB: begin
            if (n_b_ff != '0) begin
               div_start    = 1'b1;
               div_dividend = sum_b_ff;
               div_divisor  = n_b_ff;
               state_in     = ST_DIVB_WAIT;
            end else begin
               nb_in    = black_ff;
               state_in = ST_DIVW;
            end
         end
         ST_DIVB_WAIT: begin
            if (div_res.done) begin
               nb_in    = div_res.quot;
               state_in = ST_DIVW;
            end
         end
         ST_DIVW: begin
            if (n_w_ff != '0) begin
               div_start    = 1'b1;
               div_dividend = sum_w_ff;
               div_divisor  = n_w_ff;
               state_in     = ST_DIVW_WAIT;
            end else begin
               nw_in    = white_ff;
               state_in = ST_NEXT;
            end
         end
         ST_DIVW_WAIT: begin
            if (div_res.done) begin
               nw_in    = div_res.quot;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            black_in = nb_ff;
            white_in = nw_ff;
            round_in = round_ff + 1'b1;
            if (moved && (round_ff != RND_W'(MAX_ROUNDS - 1))) begin
               scan_in  = '0;
               sum_b_in = '0;
               sum_w_in = '0;
               n_b_in   = '0;
               n_w_in   = '0;
               state_in = ST_SCAN;
            end else begin
               cap_in     = moved;
               res_pix_in = '0;
               state_in   = ST_RESULT;
            end
         end
         ST_MAP_WAIT: begin
            if (div_res.done) begin
               res_pix_in = div_res.quot;
               state_in   = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = res_pix_ff;
               rsp_black_in = black_ff;
               rsp_white_in = white_ff;
               rsp_cap_in   = cap_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         black_ff     <= '0;
         white_ff     <= FULL_SCALE;
         cap_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         black_ff     <= black_in;
         white_ff     <= white_in;
         cap_ff       <= cap_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      round_ff     <= round_in;
      scan_ff      <= scan_in;
      idx_ff       <= idx_in;
      sum_b_ff     <= sum_b_in;
      sum_w_ff     <= sum_w_in;
      n_b_ff       <= n_b_in;
      n_w_ff       <= n_w_in;
      nb_ff        <= nb_in;
      nw_ff        <= nw_in;
      pix_ff       <= pix_in;
      res_pix_ff   <= res_pix_in;
      rsp_pix_ff   <= rsp_pix_in;
      rsp_black_ff <= rsp_black_in;
      rsp_white_ff <= rsp_white_in;
      rsp_cap_ff   <= rsp_cap_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.mapped_pixel  = rsp_pix_ff;
   assign rsp_chan.black_level   = rsp_black_ff;
   assign rsp_chan.white_level   = rsp_white_ff;
   assign rsp_chan.hit_round_cap = rsp_cap_ff;

endmodule

`default_nettype wire

FILE: design/tmcs_checker.sv
// ----------------------------------------------------------------------------
// tmcs_checker: port-level checks for the contrast stretch block
// Response channel holds under backpressure; request acceptance timing.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcs_checker import tmcs_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic [CMD_W-1:0] req_cmd,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [PIX_W-1:0] rsp_mapped_pixel,
   input wire logic [PIX_W-1:0] rsp_black_level,
   input wire logic [PIX_W-1:0] rsp_white_level,
   input wire logic             rsp_hit_round_cap
);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_mapped_pixel) && $stable(rsp_black_level)
                                  && $stable(rsp_white_level) && $stable(rsp_hit_round_cap))
      else $error("response payload changed while stalled");

   // accumulate reads and then writes back the histogram bin, so ready drops
   a_acc_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_cmd == CMD_ACC) |=> !req_ready)
      else $error("request taken during histogram update");

   // clear completes in the accept cycle
   a_clear_ready: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_cmd == CMD_CLEAR) |=> req_ready)
      else $error("not ready after clear");

endmodule

bind two_means_contrast_stretch tmcs_checker u_tmcs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_cmd           (req_chan.cmd),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_mapped_pixel  (rsp_chan.mapped_pixel),
   .rsp_black_level   (rsp_chan.black_level),
   .rsp_white_level   (rsp_chan.white_level),
   .rsp_hit_round_cap (rsp_chan.hit_round_cap)
);

`default_nettype wire
